// File: src/assert_macros.svh
// Assertion helpers shared by the RTL files.
// Each macro takes a label, the clock, the active-low reset, and two expressions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

// File: src/tea_pkg.sv
// ----------------------------------------------------------------------------
// tea_pkg
// Shared types, constants and elaboration-time helpers for the TEA core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tea_pkg;

    localparam int unsigned TEA_WORD_W     = 32;
    localparam int unsigned TEA_ROUNDS_DEF = 32;
    localparam int unsigned CFG_INDEX_W    = 4;
    localparam logic [TEA_WORD_W-1:0] TEA_DELTA = 32'h9e37_79b9;

    // Configuration register map
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_KEY0 = 4'd0,
        REG_KEY1 = 4'd1,
        REG_KEY2 = 4'd2,
        REG_KEY3 = 4'd3
    } tea_reg_e;

    // One block in flight, plus its direction (0 encrypt, 1 decrypt)
    typedef struct packed {
        logic                  func;
        logic [TEA_WORD_W-1:0] y;
        logic [TEA_WORD_W-1:0] z;
    } tea_lane_t;

    typedef struct packed {
        logic [TEA_WORD_W-1:0] k0;
        logic [TEA_WORD_W-1:0] k1;
        logic [TEA_WORD_W-1:0] k2;
        logic [TEA_WORD_W-1:0] k3;
    } tea_key_t;

    // delta * n mod 2^32, evaluated at elaboration for each round position
    function automatic logic [TEA_WORD_W-1:0] round_sum(int unsigned n);
        logic [2*TEA_WORD_W-1:0] prod;
        prod = (2*TEA_WORD_W)'(TEA_DELTA) * (2*TEA_WORD_W)'(n);
        return prod[TEA_WORD_W-1:0];
    endfunction

endpackage

`default_nettype wire

// File: src/tea_block_cipher_core.sv
// ----------------------------------------------------------------------------
// tea_block_cipher_core
// TEA (32-round default) block cipher core: a chain of half-round cells,
// one 64-bit block per cycle while the chain is not frozen, encryption or decryption chosen per block.
// ----------------------------------------------------------------------------
// Usage:
//   Load the 128-bit key through the cfg channel (index 0..3 = key words
//   0..3, other indexes ignored) while no block is in flight; cfg_ready is
//   always high.
//   Input stream: s_tdata = {second_word, first_word}, s_tuser = func
//   (0 encrypt, 1 decrypt). Output stream: m_tdata = {second_result,
//   first_result}.
//   Path: an accepted block is registered once per half-round cell and then
//   in the output register before it shows on m_tvalid.
//   Throughput: one block per cycle while the chain is not frozen; each cell
//   does one half-round and the whole chain advances together.
//   Stall: when m_tready is low the output register holds its result and
//   one more result lands in the skid entry; then s_tready drops and the
//   chain freezes until the master side drains.
//   Reset (aresetn low, synchronous): key words clear to zero and all
//   in-flight blocks are dropped.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module tea_block_cipher_core
    import tea_pkg::*;
#(
    parameter int unsigned ROUNDS = TEA_ROUNDS_DEF
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    // Configuration write channel
    input  wire logic                    cfg_valid,
    output logic                         cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [TEA_WORD_W-1:0]   cfg_data,
    // Input stream
    input  wire logic                    s_tvalid,
    output logic                         s_tready,
    input  wire logic [2*TEA_WORD_W-1:0] s_tdata,  // [31:0] first_word, [63:32] second_word
    input  wire logic                    s_tuser,  // [0] func
    // Result stream
    output logic                         m_tvalid,
    input  wire logic                    m_tready,
    output logic [2*TEA_WORD_W-1:0]      m_tdata   // [31:0] first_result, [63:32] second_result
);

    localparam int unsigned NCELL = 2 * ROUNDS;

    tea_key_t  key_reg;
    logic      advance;
    logic      chain_valid [0:NCELL];
    tea_lane_t chain_lane  [0:NCELL];

    // Key registers: take a write whenever the transaction completes
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (tea_reg_e'(cfg_index))
                REG_KEY0: key_reg.k0 <= cfg_data;
                REG_KEY1: key_reg.k1 <= cfg_data;
                REG_KEY2: key_reg.k2 <= cfg_data;
                REG_KEY3: key_reg.k3 <= cfg_data;
                default:  ;  // drop writes to unmapped indexes
            endcase
        end
    end

    // Feed the head of the chain straight from the slave port
    assign s_tready           = advance;
    assign chain_valid[0]     = s_tvalid;
    assign chain_lane[0].func = s_tuser;
    assign chain_lane[0].y    = s_tdata[TEA_WORD_W-1:0];
    assign chain_lane[0].z    = s_tdata[2*TEA_WORD_W-1:TEA_WORD_W];

    // Two cells per round; round r uses delta*(r+1) encrypting and
    // delta*(ROUNDS-r) decrypting.
    for (genvar i = 0; i < NCELL; i++) begin : g_cell
        localparam int unsigned RND = i / 2;
        tea_cell #(
            .HALF    (bit'(i % 2)),
            .ENC_SUM (round_sum(RND + 1)),
            .DEC_SUM (round_sum(ROUNDS - RND))
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .advance   (advance),
            .key       (key_reg),
            .in_valid  (chain_valid[i]),
            .in_lane   (chain_lane[i]),
            .out_valid (chain_valid[i+1]),
            .out_lane  (chain_lane[i+1])
        );
    end

    // Output register and skid entry; its ready paces the whole chain
    tea_skid u_skid (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (chain_valid[NCELL]),
        .in_ready  (advance),
        .in_data   ({chain_lane[NCELL].z, chain_lane[NCELL].y}),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata)
    );

    `ASSERT_NEXT(a_accept_enters_chain, aclk, aresetn, s_tvalid && s_tready, chain_valid[1])
    `ASSERT_NEXT(a_tail_holds_on_freeze, aclk, aresetn, chain_valid[NCELL] && !advance, chain_valid[NCELL] && $stable(chain_lane[NCELL]))

endmodule

`default_nettype wire

// File: src/tea_cell.sv
// ----------------------------------------------------------------------------
// tea_cell
// One half-round of TEA: updates one word of the block from the other and
// registers the result for the next cell in the chain.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tea_cell
    import tea_pkg::*;
#(
    parameter bit                    HALF    = 1'b0,
    parameter logic [TEA_WORD_W-1:0] ENC_SUM = '0,
    parameter logic [TEA_WORD_W-1:0] DEC_SUM = '0
) (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      advance,
    input  wire tea_key_t  key,
    input  wire logic      in_valid,
    input  wire tea_lane_t in_lane,
    output logic           out_valid,
    output tea_lane_t      out_lane
);

    function automatic logic [TEA_WORD_W-1:0] mix(
        input logic [TEA_WORD_W-1:0] v,
        input logic [TEA_WORD_W-1:0] sum,
        input logic [TEA_WORD_W-1:0] ka,
        input logic [TEA_WORD_W-1:0] kb
    );
        return ((v << 4) + ka) ^ (v + sum) ^ ((v >> 5) + kb);
    endfunction

    logic                  valid_reg;
    tea_lane_t             lane_reg;
    tea_lane_t             lane_next;
    logic                  upd_y;
    logic [TEA_WORD_W-1:0] src;
    logic [TEA_WORD_W-1:0] dst;
    logic [TEA_WORD_W-1:0] ka;
    logic [TEA_WORD_W-1:0] kb;
    logic [TEA_WORD_W-1:0] sum;
    logic [TEA_WORD_W-1:0] m;
    logic [TEA_WORD_W-1:0] dst_new;

    // Encrypt updates y first then z; decrypt runs the halves mirrored.
    always_comb begin
        upd_y   = (HALF == 1'b0) ^ in_lane.func;
        src     = upd_y ? in_lane.z : in_lane.y;
        dst     = upd_y ? in_lane.y : in_lane.z;
        ka      = upd_y ? key.k0 : key.k2;
        kb      = upd_y ? key.k1 : key.k3;
        sum     = in_lane.func ? DEC_SUM : ENC_SUM;
        m       = mix(src, sum, ka, kb);
        dst_new = in_lane.func ? (dst - m) : (dst + m);
        lane_next      = in_lane;
        if (upd_y) begin
            lane_next.y = dst_new;
        end else begin
            lane_next.z = dst_new;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (advance) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            lane_reg <= lane_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_lane  = lane_reg;

endmodule

`default_nettype wire

// File: src/tea_skid.sv
// ----------------------------------------------------------------------------
// tea_skid
// Output register with one skid entry, so the cell chain sees a registered
// ready and keeps moving while one result waits on the master side.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module tea_skid
    import tea_pkg::*;
(
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    in_valid,
    output logic                         in_ready,
    input  wire logic [2*TEA_WORD_W-1:0] in_data,
    output logic                         out_valid,
    input  wire logic                    out_ready,
    output logic [2*TEA_WORD_W-1:0]      out_data
);

    logic                    out_valid_reg;
    logic                    out_valid_next;
    logic [2*TEA_WORD_W-1:0] out_data_reg;
    logic [2*TEA_WORD_W-1:0] out_data_next;
    logic                    skid_valid_reg;
    logic                    skid_valid_next;
    logic [2*TEA_WORD_W-1:0] skid_data_reg;
    logic [2*TEA_WORD_W-1:0] skid_data_next;
    logic                    push;

    assign in_ready = !skid_valid_reg;
    assign push     = in_valid && in_ready;

    always_comb begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (!out_valid_reg || out_ready) begin
            // Output slot frees: drain the skid entry first
            if (skid_valid_reg) begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end else begin
                out_valid_next = push;
                out_data_next  = in_data;
            end
        end else if (push) begin
            // Stalled: park the arriving result
            skid_valid_next = 1'b1;
            skid_data_next  = in_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    `ASSERT_IMPLIES(a_skid_behind_out, aclk, aresetn, skid_valid_reg, out_valid_reg)
    `ASSERT_NEXT(a_stall_parks, aclk, aresetn, out_valid_reg && !out_ready && push, skid_valid_reg && (skid_data_reg == $past(in_data)))

endmodule

`default_nettype wire
